[rtl/ternary_popcount_dot_product_unit_defines.svh]
// Assertion macros for the ternary popcount dot product unit.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef TERNARY_POPCOUNT_DOT_PRODUCT_UNIT_DEFINES_SVH
`define TERNARY_POPCOUNT_DOT_PRODUCT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPDP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TPDP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tpdp_pkg.sv]
// Shared types, constants and the slice popcount for the ternary dot product unit.
// No dependencies.
`default_nettype none

package tpdp_pkg;

  localparam int WORD_W    = 32;
  localparam int LANE_BITS = 32;
  localparam int MAX_WORDS = 64;
  localparam int HALF_BITS = LANE_BITS / 2;
  localparam int SUM_BOUND = MAX_WORDS * HALF_BITS;

  localparam int SUM_W = 12;
  localparam int EXT_W = SUM_W + 1;

  // Each lane handles one byte of the word.
  localparam int SLICE_W   = 8;
  localparam int NUM_LANES = WORD_W / SLICE_W;
  localparam int CNT_W     = $clog2(SLICE_W + 1);
  localparam int TOT_W     = $clog2(WORD_W + 1);

  localparam logic [63:0] LANE_MASK64 =
    (LANE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LANE_BITS) - 64'd1);
  localparam logic [WORD_W-1:0] LANE_MASK = LANE_MASK64[WORD_W-1:0];

  typedef struct packed {
    logic [WORD_W-1:0] input_bits;
    logic [WORD_W-1:0] and_mask;
    logic [WORD_W-1:0] or_mask;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    fires;
  } out_item_t;

  typedef struct packed {
    logic step;
    logic last;
    logic load;
  } merge_ctrl_t;

  typedef logic [NUM_LANES-1:0][CNT_W-1:0] lane_cnt_t;

  // Pairwise popcount of one byte.
  function automatic logic [CNT_W-1:0] slice_popcount(input logic [SLICE_W-1:0] w);
    logic [SLICE_W-1:0] a;
    logic [SLICE_W-1:0] b;
    logic [SLICE_W-1:0] c;
    a = w - ((w >> 1) & 8'h55);
    b = ((a >> 2) & 8'h33) + (a & 8'h33);
    c = ((b >> 4) + b) & 8'h0f;
    return c[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/ternary_popcount_dot_product_unit.sv]
// Channel  | Ports                          | Moves
// ---------+--------------------------------+-----------------------------------------
// input    | in_valid, in_ready, in_data    | one word: inputs, two masks, last flag
// result   | out_valid, out_ready, out_data | saturated sum and fire flag, per vector
//
// One word per cycle sustained unless a last word waits on a stalled result; the
// result of a last word passes two register stages from in_data to out_data.
// Stage one is the byte lanes (ternary mask plus popcount), stage two is the merge
// adder with the saturating accumulator and the result register.
// Reset (synchronous, rst_n low) empties both stages and zeroes the accumulator.
// A stalled result holds only a following last word, which then blocks the input;
// words that are not last keep flowing behind the stalled result.
//
// Top level of the ternary popcount dot product unit.
// Depends on tpdp_pkg, tpdp_lane, tpdp_merge and the assertion macro header.
`default_nettype none
`include "ternary_popcount_dot_product_unit_defines.svh"

module ternary_popcount_dot_product_unit
  import tpdp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic        s1_last_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        in_fire;
  logic        s1_move;
  logic        out_load;
  merge_ctrl_t mctrl;
  lane_cnt_t   lane_cnt;

  // A word that is not last never needs the result register, so it always
  // advances; a last word waits until the result register is free or draining.
  assign s1_move  = s1_valid_r & (~s1_last_r | ~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_move;
  assign in_fire  = in_valid & in_ready;
  assign out_load = s1_move & s1_last_r;

  assign mctrl.step = s1_move;
  assign mctrl.last = s1_last_r;
  assign mctrl.load = out_load;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the last flag alongside the lane counts.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_last_r <= in_data.is_last;
    end
  end

  // Byte lanes: each takes its slice of the word and counts the weighted ones.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    tpdp_lane u_lane (
      .clk    (clk),
      .load   (in_fire),
      .x_bits (in_data.input_bits[g*SLICE_W +: SLICE_W]),
      .a_bits (in_data.and_mask[g*SLICE_W +: SLICE_W]),
      .o_bits (in_data.or_mask[g*SLICE_W +: SLICE_W]),
      .m_bits (LANE_MASK[g*SLICE_W +: SLICE_W]),
      .cnt_r  (lane_cnt[g])
    );
  end

  // Merge the lane counts into the running sum and hold the vector result.
  tpdp_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (mctrl),
    .lane_cnt (lane_cnt),
    .result_r (out_data)
  );

  assign out_valid = out_valid_r;

  // Never overwrite a result that has not been taken.
  `TPDP_ASSERT_IMP(a_no_overwrite, out_load, !out_valid_r || out_ready, "result overwritten")
  // A moved last word shows up as a result in the next cycle.
  `TPDP_ASSERT_NXT(a_load_shows, out_load, out_valid_r, "result not presented")
  // The presented sum stays within the saturation bound.
  `TPDP_ASSERT_IMP(a_sum_bound, out_valid_r,
    ($signed(out_data.sum) <= $signed(SUM_W'(SUM_BOUND))) &&
    ($signed(out_data.sum) >= -$signed(SUM_W'(SUM_BOUND))), "sum outside bound")
  // The fire flag agrees with the sign of the sum.
  `TPDP_ASSERT_IMP(a_fires_sign, out_valid_r, out_data.fires == !out_data.sum[SUM_W-1],
    "fire flag disagrees with sum")

endmodule

`default_nettype wire

[rtl/tpdp_lane.sv]
// One byte lane: applies the ternary weights and registers the bit count.
// Depends on tpdp_pkg.
`default_nettype none

module tpdp_lane
  import tpdp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic [SLICE_W-1:0] x_bits,
  input  wire logic [SLICE_W-1:0] a_bits,
  input  wire logic [SLICE_W-1:0] o_bits,
  input  wire logic [SLICE_W-1:0] m_bits,
  output logic      [CNT_W-1:0]   cnt_r
);

  logic [SLICE_W-1:0] weighted;
  logic [CNT_W-1:0]   cnt_nxt;

  assign weighted = ((x_bits & a_bits) ^ (x_bits | o_bits)) & m_bits;
  assign cnt_nxt  = slice_popcount(weighted);

  always_ff @(posedge clk) begin
    if (load) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/tpdp_merge.sv]
// Merge stage: adds the lane counts, accumulates with saturation, holds the result.
// Depends on tpdp_pkg.
`default_nettype none

module tpdp_merge
  import tpdp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire merge_ctrl_t ctrl,
  input  wire lane_cnt_t   lane_cnt,
  output out_item_t        result_r
);

  localparam logic signed [EXT_W-1:0] POS_BOUND = EXT_W'(SUM_BOUND);
  localparam logic signed [EXT_W-1:0] NEG_BOUND = -EXT_W'(SUM_BOUND);

  logic signed [SUM_W-1:0] acc_r;
  logic signed [SUM_W-1:0] acc_nxt;
  logic [TOT_W-1:0]        total;
  logic signed [EXT_W-1:0] raw;
  logic signed [SUM_W-1:0] sat;

  always_comb begin
    total = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      total = total + TOT_W'(lane_cnt[i]);
    end
    raw = {acc_r[SUM_W-1], acc_r} + $signed(EXT_W'(total)) - $signed(EXT_W'(HALF_BITS));
    if (raw > POS_BOUND) begin
      sat = POS_BOUND[SUM_W-1:0];
    end else if (raw < NEG_BOUND) begin
      sat = NEG_BOUND[SUM_W-1:0];
    end else begin
      sat = raw[SUM_W-1:0];
    end
    // Clear after the closing word of a vector.
    acc_nxt = ctrl.last ? '0 : sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctrl.step) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      result_r.sum   <= sat;
      result_r.fires <= ~sat[SUM_W-1];
    end
  end

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the ternary popcount dot product unit.
// Needs tpdp_pkg and the ternary_popcount_dot_product_unit RTL.
`default_nettype none

module testbench;
  import tpdp_pkg::*;

  // How the mask words of one vector are drawn.
  typedef enum int {
    BIAS_FLAT,
    BIAS_HIGH,
    BIAS_LOW
  } word_bias_e;

  typedef struct {
    in_item_t word;
    bit       drain;   // hold this item until every owed result has come back
  } queued_word_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  queued_word_t word_q[$];
  out_item_t    owed_sums_q[$];
  int           results_owed = 0;
  int           err_count = 0;
  int           words_queued = 0;

  // Running sum of the predictor, mirrors the block's accumulator.
  int           acc_sum = 0;

  // Driver and receiver pacing state.
  int           send_gap = 0;
  bit           send_steady = 1'b0;
  bit           drain_armed = 1'b0;
  int           stall_left = 0;
  bit           recv_steady = 1'b0;

  // Monitor scratch.
  bit           has_sum;
  out_item_t    pred_sum;
  out_item_t    want_sum;
  int           owed_delta;

  ternary_popcount_dot_product_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones; none at all while steady.
  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply the ternary weights to one word, fold it into the running sum
  // and produce the neuron result when the word closes the vector.
  task automatic fold_word(input in_item_t w, output bit done, output out_item_t res);
    logic [WORD_W-1:0] lanes;
    int                v;
    lanes = ((w.input_bits & w.and_mask) ^ (w.input_bits | w.or_mask)) & LANE_MASK;
    v = acc_sum + $countones(lanes) - HALF_BITS;
    // clamp after every word, so long vectors pin at the bound
    if (v > SUM_BOUND) begin
      v = SUM_BOUND;
    end else if (v < -SUM_BOUND) begin
      v = -SUM_BOUND;
    end
    acc_sum = v;
    done = w.is_last;
    res = '0;
    if (w.is_last) begin
      res.sum = v[SUM_W-1:0];
      res.fires = (v >= 0);
      acc_sum = 0;
    end
  endtask

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic add_word(input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] a,
                          input logic [WORD_W-1:0] o, input bit last, input bit drain);
    queued_word_t q;
    q.word.input_bits = x;
    q.word.and_mask = a;
    q.word.or_mask = o;
    q.word.is_last = last;
    q.drain = drain;
    word_q.push_back(q);
    words_queued++;
  endtask

  // One vector of random words; the bias steers the sum toward a bound.
  task automatic add_vector(input int len, input word_bias_e bias, input bit drain);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] o;
    for (int i = 0; i < len; i++) begin
      case (bias)
        BIAS_HIGH: begin
          a = $urandom & $urandom & $urandom;
          o = $urandom | $urandom | $urandom;
        end
        BIAS_LOW: begin
          a = $urandom | $urandom | $urandom;
          o = $urandom & $urandom & $urandom;
        end
        default: begin
          a = $urandom;
          o = $urandom;
        end
      endcase
      add_word($urandom, a, o, i == len - 1, drain && i == 0);
    end
  endtask

  // Driver: present the next queued item once the previous one is taken
  // and the chosen gap has run out. Valid holds while the block stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap = 0;
      drain_armed = 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if ($urandom_range(0, 199) == 0) send_steady = !send_steady;
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (word_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (word_q[0].drain && (!drain_armed || results_owed != 0)) begin
        // hold off first so the owed count reflects the last item
        in_valid <= 1'b0;
        drain_armed = 1'b1;
      end else begin
        in_valid <= 1'b1;
        in_data <= word_q[0].word;
        void'(word_q.pop_front());
        drain_armed = 1'b0;
        send_gap = pick_gap(send_steady);
      end
    end
  end

  // Receiver: ready drops for random stretches, with steady phases between.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if ($urandom_range(0, 199) == 0) recv_steady = !recv_steady;
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap(recv_steady);
      end
    end
  end

  // Monitor: predict on every accepted item, check every accepted result
  // against the oldest owed sum.
  always @(posedge clk) begin
    if (!rst_n) begin
      acc_sum = 0;
      results_owed <= 0;
    end else begin
      owed_delta = 0;
      if (in_valid && in_ready) begin
        fold_word(in_data, has_sum, pred_sum);
        if (has_sum) begin
          owed_sums_q.push_back(pred_sum);
          owed_delta++;
        end
      end
      if (out_valid && out_ready) begin
        if (owed_sums_q.size() == 0) begin
          note_failure($sformatf("result with none owed: sum=%0d fires=%0b",
                                 out_data.sum, out_data.fires));
        end else begin
          want_sum = owed_sums_q.pop_front();
          owed_delta--;
          if (out_data.sum !== want_sum.sum || out_data.fires !== want_sum.fires) begin
            note_failure($sformatf("sum exp %0d got %0d, fires exp %0b got %0b",
                                   want_sum.sum, out_data.sum,
                                   want_sum.fires, out_data.fires));
          end
        end
      end
      results_owed <= results_owed + owed_delta;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int         r;
    int         len;
    word_bias_e bias;
    bit         first;

    // Directed words: mask extremes, each weight code, the sign boundary.
    add_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    add_word(32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    add_word(32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 1'b1, 1'b0);
    add_word(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b0);
    add_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0);
    add_word(32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0);
    // exactly half set: sum zero, fires
    add_word(32'haaaa_aaaa, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    // one short of half: sum minus one, no fire
    add_word(32'h0000_7fff, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    // words that are not last only accumulate
    add_word(32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
    add_word(32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 1'b0, 1'b0);
    add_word(32'h0001_ffff, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    add_word(32'h1234_5678, 32'hf0f0_f0f0, 32'hff00_ff00, 1'b1, 1'b0);
    add_word(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 1'b0, 1'b0);
    add_word(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000, 1'b0, 1'b0);
    add_word(32'h8000_0001, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    add_word(32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa, 1'b1, 1'b0);

    // Random vectors: mostly short, some full length, a few past the
    // word budget so the clamp engages in both directions.
    first = 1'b1;
    while (words_queued < 1950) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = $urandom_range(1, 8);
      end else if (r < 93) begin
        len = $urandom_range(9, MAX_WORDS);
      end else begin
        len = $urandom_range(MAX_WORDS + 1, MAX_WORDS + 30);
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        bias = BIAS_FLAT;
      end else if (r < 80) begin
        bias = BIAS_HIGH;
      end else begin
        bias = BIAS_LOW;
      end
      add_vector(len, bias, first || $urandom_range(0, 39) == 0);
      first = 1'b0;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge to stay clear of the driver's updates.
    do @(negedge clk); while (word_q.size() != 0 || in_valid);
    while (results_owed != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/tpdp_pkg.sv
rtl/tpdp_lane.sv
rtl/tpdp_merge.sv
rtl/ternary_popcount_dot_product_unit.sv
test/testbench.sv
